FILE: src/led_matrix_frame_receiver_scanner_assert.svh
// assertion macros shared by the frame receiver and scanner rtl
`ifndef LED_MATRIX_FRAME_RECEIVER_SCANNER_ASSERT_SVH
`define LED_MATRIX_FRAME_RECEIVER_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define LMFRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lmfrs assertion failed");

// next-cycle implication, checked outside reset
`define LMFRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lmfrs assertion failed");

`else

`define LMFRS_ASSERT_IMP(lbl, ante, cons)
`define LMFRS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: src/lmfrs_pkg.sv
// shared types, constants and helpers for the frame receiver and scanner
`timescale 1ns / 1ps
`default_nettype none

package lmfrs_pkg;

    // default sizes
    localparam int FRAME_BYTES_DEF = 32;
    localparam int SCAN_ROWS_DEF   = 16;

    // request and result kinds
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_REFRESH = 1'b1;
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    // protocol bytes
    localparam logic [7:0] ADDR_FD  = 8'hFD;
    localparam logic [7:0] ADDR_FC  = 8'hFC;
    localparam logic [7:0] ADDR_FA  = 8'hFA;
    localparam logic [7:0] ADDR_F9  = 8'hF9;
    localparam logic [7:0] CMD_LOAD = 8'hAB;
    localparam logic [7:0] CMD_RING = 8'hAC;
    localparam logic [7:0] RING_ON  = 8'h31;

    // width of the one-hot row select in a shift word
    localparam int ROW_SEL_W = 16;

    // classified item passed from front to back
    typedef struct packed {
        logic       is_refresh;
        logic       is_addr;
        logic       is_load_cmd;
        logic       is_ring_cmd;
        logic       ring_on;
        logic [7:0] rev_byte;
    } item_t;

    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[b] = v[7 - b];
        end
        return r;
    endfunction

    function automatic logic is_address(input logic [7:0] v);
        return (v == ADDR_FD) || (v == ADDR_FC) || (v == ADDR_FA) || (v == ADDR_F9);
    endfunction

endpackage

`default_nettype wire

FILE: src/lmfrs_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lmfrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/lmfrs_front.sv
// front end: accepts requests, decodes protocol bytes and queues them
`timescale 1ns / 1ps
`default_nettype none

module lmfrs_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,   // rx_byte[7:0]
    input  wire logic            s_tuser,   // req_type[0]
    output logic                 q_vld,
    output lmfrs_pkg::item_t     q_item,
    input  wire logic            q_pop
);

    import lmfrs_pkg::*;

    item_t      ent_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      dec;
    logic       push;

    // decode the incoming transaction
    always_comb begin
        dec.is_refresh  = (s_tuser == REQ_REFRESH);
        dec.is_addr     = is_address(s_tdata);
        dec.is_load_cmd = (s_tdata == CMD_LOAD);
        dec.is_ring_cmd = (s_tdata == CMD_RING);
        dec.ring_on     = (s_tdata == RING_ON);
        dec.rev_byte    = bit_rev8(s_tdata);
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_vld    = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rptr_reg];

    // queue pointers and fill level
    always_comb begin
        wptr_next = push  ? ~wptr_reg : wptr_reg;
        rptr_next = q_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

FILE: src/lmfrs_back.sv
// back end: frame parser, banked frame store and row scanner with output register
`timescale 1ns / 1ps
`default_nettype none

module lmfrs_back #(
    parameter int FRAME_BYTES = lmfrs_pkg::FRAME_BYTES_DEF,
    parameter int SCAN_ROWS   = lmfrs_pkg::SCAN_ROWS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_vld,
    input  wire lmfrs_pkg::item_t q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [39:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    import lmfrs_pkg::*;

    `include "led_matrix_frame_receiver_scanner_assert.svh"

    localparam int BANK_DEPTH = (FRAME_BYTES + 1) / 2;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WI_W       = $clog2(FRAME_BYTES);
    localparam int ROW_W      = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } scan_state_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ADDR = 4'b0010,
        PH_LOAD = 4'b0100,
        PH_RING = 4'b1000
    } phase_t;

    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             done;
        logic             lamp;
        logic             buzz;
        logic             even_ok;
        logic             odd_ok;
    } stage_t;

    scan_state_t      state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    phase_t           phase_reg, phase_next, phase_mid;
    logic [WI_W-1:0]  widx_reg, widx_next;
    logic             ring_reg, ring_next;
    logic             buzz_reg, buzz_next;
    logic [BANK_DEPTH-1:0] even_vld_reg, odd_vld_reg;
    logic             s1_vld_reg;
    stage_t           s1_reg, s1_next;
    logic             m_vld_reg;
    logic [39:0]      m_data_reg, m_data_next;
    logic             m_kind_reg, m_last_reg;

    logic             out_free, issue_ok, issue_row, issue_byte, row_last, done_flag;
    logic [ROW_W-1:0] row_cur;
    logic [31:0]      row32, s1_row32;
    logic             even_in, odd_in;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             wr_en, wr_odd;
    logic [7:0]       even_q, odd_q, even_b, odd_b;
    logic [ROW_SEL_W-1:0] sel;

    // handshake between stages
    assign out_free   = !m_vld_reg || m_tready;
    assign issue_ok   = !s1_vld_reg || out_free;
    assign issue_row  = issue_ok && (((state_reg == ST_IDLE) && q_vld && q_item.is_refresh)
                                     || (state_reg == ST_SCAN));
    assign issue_byte = issue_ok && (state_reg == ST_IDLE) && q_vld && !q_item.is_refresh;
    assign q_pop      = issue_ok && (state_reg == ST_IDLE) && q_vld;

    // current row and its store addresses
    assign row_cur  = (state_reg == ST_SCAN) ? row_reg : '0;
    assign row_last = (row_cur == ROW_W'(SCAN_ROWS - 1));
    assign row32    = 32'(row_cur);
    assign even_in  = (row32 * 32'd2) < 32'(FRAME_BYTES);
    assign odd_in   = (row32 * 32'd2 + 32'd1) < 32'(FRAME_BYTES);
    assign rd_addr  = AW'(row32);

    // store write for a loading byte
    assign wr_en   = issue_byte && (phase_reg == PH_LOAD);
    assign wr_addr = AW'(widx_reg >> 1);
    assign wr_odd  = widx_reg[0];

    // scan sequencer
    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        buzz_next  = buzz_reg;
        if (issue_row) begin
            if (row_last) begin
                state_next = ST_IDLE;
                row_next   = '0;
                if (ring_reg) begin
                    buzz_next = ~buzz_reg;
                end
            end else begin
                state_next = ST_SCAN;
                row_next   = row_cur + 1'b1;
            end
        end
    end

    // frame parser
    always_comb begin
        phase_mid = phase_reg;
        widx_next = widx_reg;
        ring_next = ring_reg;
        done_flag = 1'b0;
        unique case (phase_reg)
            PH_LOAD: begin
                if (widx_reg == WI_W'(FRAME_BYTES - 1)) begin
                    widx_next = '0;
                    phase_mid = PH_IDLE;
                    done_flag = 1'b1;
                end else begin
                    widx_next = widx_reg + 1'b1;
                end
            end
            PH_RING: begin
                ring_next = q_item.ring_on;
                phase_mid = PH_IDLE;
            end
            PH_ADDR: begin
                if (q_item.is_load_cmd) begin
                    phase_mid = PH_LOAD;
                end else if (q_item.is_ring_cmd) begin
                    phase_mid = PH_RING;
                end else begin
                    phase_mid = PH_IDLE;
                end
            end
            PH_IDLE: phase_mid = PH_IDLE;
            default: phase_mid = PH_IDLE;
        endcase
        // address check also runs on the byte that closed a frame
        phase_next = ((phase_mid == PH_IDLE) && q_item.is_addr) ? PH_ADDR : phase_mid;
        if (!issue_byte) begin
            phase_next = phase_reg;
            widx_next  = widx_reg;
            ring_next  = ring_reg;
            done_flag  = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            phase_reg    <= PH_IDLE;
            widx_reg     <= '0;
            ring_reg     <= 1'b0;
            buzz_reg     <= 1'b1;
            even_vld_reg <= '0;
            odd_vld_reg  <= '0;
            s1_vld_reg   <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            widx_reg  <= widx_next;
            ring_reg  <= ring_next;
            buzz_reg  <= buzz_next;
            if (wr_en && !wr_odd) begin
                even_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_en && wr_odd) begin
                odd_vld_reg[wr_addr] <= 1'b1;
            end
            if (issue_row || issue_byte) begin
                s1_vld_reg <= 1'b1;
            end else if (out_free) begin
                s1_vld_reg <= 1'b0;
            end
            if (out_free) begin
                m_vld_reg <= s1_vld_reg;
            end
        end
    end

    // even and odd store banks
    lmfrs_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH), .AW(AW)) u_even (
        .aclk  (aclk),
        .we    (wr_en && !wr_odd),
        .waddr (wr_addr),
        .wdata (q_item.rev_byte),
        .re    (issue_row),
        .raddr (rd_addr),
        .rdata (even_q)
    );

    lmfrs_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH), .AW(AW)) u_odd (
        .aclk  (aclk),
        .we    (wr_en && wr_odd),
        .waddr (wr_addr),
        .wdata (q_item.rev_byte),
        .re    (issue_row),
        .raddr (rd_addr),
        .rdata (odd_q)
    );

    // read stage payload
    always_comb begin
        s1_next.kind    = issue_row ? KIND_ROW : KIND_ACK;
        s1_next.row     = row_cur;
        s1_next.last    = issue_row ? row_last : 1'b1;
        s1_next.done    = done_flag;
        s1_next.lamp    = ring_next;
        s1_next.buzz    = buzz_next;
        s1_next.even_ok = even_in && even_vld_reg[rd_addr];
        s1_next.odd_ok  = odd_in && odd_vld_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (issue_row || issue_byte) begin
            s1_reg <= s1_next;
        end
    end

    // build the result word, unwritten store bytes read as all ones
    always_comb begin
        s1_row32 = 32'(s1_reg.row);
        even_b   = s1_reg.even_ok ? ~even_q : 8'hFF;
        odd_b    = s1_reg.odd_ok  ? ~odd_q  : 8'hFF;
        sel      = (s1_row32 < 32'(ROW_SEL_W)) ? (ROW_SEL_W'(1) << s1_row32[3:0]) : '0;
        m_data_next = '0;
        if (s1_reg.kind == KIND_ROW) begin
            m_data_next[31:0]  = {odd_b, even_b, sel};
            m_data_next[35:32] = s1_row32[3:0];
        end
        m_data_next[36] = s1_reg.done;
        m_data_next[37] = s1_reg.lamp;
        m_data_next[38] = s1_reg.buzz;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_free && s1_vld_reg) begin
            m_data_reg <= m_data_next;
            m_kind_reg <= s1_reg.kind;
            m_last_reg <= s1_reg.last;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `LMFRS_ASSERT_IMP(a_done_only_on_ack, m_vld_reg && (m_kind_reg == KIND_ROW), !m_data_reg[36])
    `LMFRS_ASSERT_IMP(a_scan_row_nonzero, state_reg == ST_SCAN, row_reg != '0)
    `LMFRS_ASSERT_IMP(a_widx_only_loading, widx_reg != '0, phase_reg == PH_LOAD)
    `LMFRS_ASSERT_NXT(a_buzz_needs_ring, !ring_reg, $stable(buzz_reg))
    `LMFRS_ASSERT_IMP(a_no_pop_in_scan, state_reg == ST_SCAN, !q_pop)

endmodule

`default_nettype wire

FILE: src/led_matrix_frame_receiver_scanner.sv
// m_tvalid is registered; a request passes the queue, the read stage and the output register.
// Throughput while m_tready holds: one byte transaction per cycle outside a scan; a refresh gives
// SCAN_ROWS row words, one per cycle, set by one read per cycle in each of the even and odd banks.
// Reset: synchronous active-low aresetn clears parser, scanner and queue state and the per-entry
// valid bits of the frame store, so the store reads as all ones (8'hFF) with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_frame_receiver_scanner #(
    parameter int FRAME_BYTES = lmfrs_pkg::FRAME_BYTES_DEF,
    parameter int SCAN_ROWS   = lmfrs_pkg::SCAN_ROWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  wire logic        s_tuser,   // req_type[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // shift_word[31:0], row_index[35:32], frame_done[36],
                                        // lamp_on[37], buzzer_level[38], zero[39]
    output logic             m_tuser,   // result_kind[0]
    output logic             m_tlast    // last
);

    import lmfrs_pkg::*;

    logic  q_vld;
    item_t q_item;
    logic  q_pop;

    // request decode and queue
    lmfrs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_vld    (q_vld),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // parser, frame store and scanner
    lmfrs_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .SCAN_ROWS   (SCAN_ROWS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_vld    (q_vld),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
